### hdl/ssws_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment write sequencer package
// Shared types and constants for the command front end, queue and write back end.
// ----------------------------------------------------------------------------
package ssws_pkg;

	// Command codes carried on the input tuser.
	typedef enum logic [2:0] {
		REQ_DIGIT   = 3'd0,
		REQ_RAW     = 3'd1,
		REQ_HEX16   = 3'd2,
		REQ_DEC16   = 3'd3,
		REQ_HEX8    = 3'd4,
		REQ_CLR_ALL = 3'd5,
		REQ_CLR_LN  = 3'd6,
		REQ_ERROR   = 3'd7
	} ssws_req_t;

	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 8;

	localparam logic [7:0] CTRL_DECODED = 8'b0101_1000;
	localparam logic [7:0] CTRL_RAW     = 8'b0111_1000;
	localparam logic [7:0] DP_BIT       = 8'h80;
	localparam logic [7:0] BLANK_SEGS   = 8'b1000_0000;
	localparam logic [7:0] ERR_SEG0     = 8'b1100_1111;
	localparam logic [7:0] ERR_SEG1     = 8'b1000_1100;
	localparam logic [7:0] ERR_SEG2     = 8'b1000_1100;
	localparam logic [7:0] ERR_SEG3     = 8'b1111_0000;

	localparam logic [15:0] DEC_MAX = 16'd9999;

	// Reciprocal multipliers for the decimal split, exact over the used ranges.
	localparam logic [13:0] RECIP_1000 = 14'd8389;  // >> 23, value up to 9999
	localparam logic [5:0]  RECIP_100  = 6'd41;     // >> 12, value up to 999
	localparam logic [6:0]  RECIP_10   = 7'd103;    // >> 10, value up to 99

	// One run of digit writes: cnt digits starting at addr0, address wrapping
	// modulo eight, data byte taken from data[digit index mod 4].
	typedef struct packed {
		logic            raw;
		logic [2:0]      addr0;
		logic [3:0]      cnt;
		logic [3:0][7:0] data;
	} ssws_run_t;

endpackage

### hdl/ssws_front.sv
// ----------------------------------------------------------------------------
// Seven-segment write sequencer command front end
// Accepts commands, builds a run descriptor and splits decimal values in two stages.
// ----------------------------------------------------------------------------
module ssws_front import ssws_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic [IN_TUSER_W-1:0] s_axis_tuser,
	input  logic                  q_full,
	output logic                  push,
	output ssws_run_t             push_run
);

	logic [3:0]  digit_addr;
	logic [15:0] value;
	logic        dp_on;
	logic        line_sel;
	logic [7:0]  lo;
	ssws_run_t   run_c;
	logic        dec_c;
	logic [29:0] th_prod;
	logic [3:0]  th_c;
	logic [15:0] r1_full;

	logic        v_s1, v_s2;
	ssws_run_t   run_s1, run_s2;
	logic        dec_s1, dec_s2;
	logic [3:0]  th_s1, th_s2;
	logic [9:0]  r1_s1;
	logic [3:0]  h_s2;
	logic [6:0]  r2_s2;

	logic [15:0] h_prod;
	logic [3:0]  h_c;
	logic [9:0]  r2_full;
	logic [13:0] t_prod;
	logic [3:0]  t_c;
	logic [6:0]  o_full;
	logic        advance;

	assign digit_addr = s_axis_tdata[3:0];
	assign value      = s_axis_tdata[19:4];
	assign dp_on      = s_axis_tdata[20];
	assign line_sel   = s_axis_tdata[21];
	assign lo         = value[7:0];

	assign advance       = !v_s2 || !q_full;
	assign s_axis_tready = advance;

	always_comb begin
		run_c = '0;
		dec_c = 1'b0;
		unique case (ssws_req_t'(s_axis_tuser))
			REQ_DIGIT: begin
				run_c.addr0   = digit_addr[2:0];
				run_c.cnt     = 4'd1;
				run_c.data[0] = {~dp_on, lo[6:0]};
			end
			REQ_RAW: begin
				run_c.raw     = 1'b1;
				run_c.addr0   = digit_addr[2:0];
				run_c.cnt     = 4'd1;
				run_c.data[0] = lo;
			end
			REQ_HEX16: begin
				run_c.addr0   = {line_sel, 2'b00};
				run_c.cnt     = 4'd4;
				run_c.data[0] = DP_BIT | {4'h0, value[15:12]};
				run_c.data[1] = DP_BIT | {4'h0, value[11:8]};
				run_c.data[2] = DP_BIT | {4'h0, value[7:4]};
				run_c.data[3] = DP_BIT | {4'h0, value[3:0]};
			end
			REQ_DEC16: begin
				dec_c       = 1'b1;
				run_c.addr0 = {line_sel, 2'b00};
				run_c.cnt   = (value <= DEC_MAX) ? 4'd4 : 4'd0;
			end
			REQ_HEX8: begin
				run_c.addr0   = digit_addr[2:0];
				run_c.cnt     = digit_addr[3] ? 4'd0 : 4'd2;
				run_c.data[0] = DP_BIT | {4'h0, lo[7:4]};
				run_c.data[1] = DP_BIT | {4'h0, lo[3:0]};
			end
			REQ_CLR_ALL: begin
				run_c.raw  = 1'b1;
				run_c.cnt  = 4'd8;
				run_c.data = {4{BLANK_SEGS}};
			end
			REQ_CLR_LN: begin
				run_c.raw   = 1'b1;
				run_c.addr0 = {line_sel, 2'b00};
				run_c.cnt   = 4'd4;
				run_c.data  = {4{BLANK_SEGS}};
			end
			REQ_ERROR: begin
				run_c.raw   = 1'b1;
				run_c.addr0 = {line_sel, 2'b00};
				run_c.cnt   = 4'd4;
				run_c.data  = {ERR_SEG3, ERR_SEG2, ERR_SEG1, ERR_SEG0};
			end
			default: run_c = '0;
		endcase
	end

	// Thousands digit and remainder below one thousand.
	assign th_prod = {14'd0, value} * {16'd0, RECIP_1000};
	assign th_c    = th_prod[26:23];
	assign r1_full = value - ({12'd0, th_c} * 16'd1000);

	// Hundreds digit and remainder below one hundred.
	assign h_prod  = {6'd0, r1_s1} * {10'd0, RECIP_100};
	assign h_c     = h_prod[15:12];
	assign r2_full = r1_s1 - ({6'd0, h_c} * 10'd100);

	// Tens and ones.
	assign t_prod = {7'd0, r2_s2} * {7'd0, RECIP_10};
	assign t_c    = t_prod[13:10];
	assign o_full = r2_s2 - ({3'd0, t_c} * 7'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			run_s1 <= run_c;
			dec_s1 <= dec_c;
			th_s1  <= th_c;
			r1_s1  <= r1_full[9:0];
			run_s2 <= run_s1;
			dec_s2 <= dec_s1;
			th_s2  <= th_s1;
			h_s2   <= h_c;
			r2_s2  <= r2_full[6:0];
		end
	end

	// Runs with no digit writes are dropped here.
	assign push = v_s2 && !q_full && (run_s2.cnt != 4'd0);

	always_comb begin
		push_run = run_s2;
		if (dec_s2) begin
			push_run.data[0] = DP_BIT | {4'h0, th_s2};
			push_run.data[1] = DP_BIT | {4'h0, h_s2};
			push_run.data[2] = DP_BIT | {4'h0, t_c};
			push_run.data[3] = DP_BIT | {4'h0, o_full[3:0]};
		end
	end

endmodule

### hdl/ssws_queue.sv
// ----------------------------------------------------------------------------
// Seven-segment write sequencer run queue
// Two-entry queue of run descriptors between the front end and the back end.
// ----------------------------------------------------------------------------
module ssws_queue import ssws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ssws_run_t push_run,
	input  logic      pop,
	output logic      full,
	output logic      head_valid,
	output ssws_run_t head
);

	ssws_run_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_run;
	end

endmodule

### hdl/ssws_back.sv
// ----------------------------------------------------------------------------
// Seven-segment write sequencer write back end
// Walks one run descriptor and emits a control and a data word per digit.
// ----------------------------------------------------------------------------
module ssws_back import ssws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  ssws_run_t              q_head,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tuser,
	output logic                   m_axis_tlast
);

	ssws_run_t  cur_q;
	logic       cur_v_q;
	logic [2:0] idx_q;
	logic       ph_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_mode_q;
	logic       out_last_q;

	logic       load_out;
	logic       step;
	logic       fin;
	logic       take;
	logic [2:0] addr;
	logic [7:0] ctrl_byte;
	logic [7:0] gen_byte;

	assign load_out  = !out_v_q || m_axis_tready;
	assign step      = cur_v_q && load_out;
	assign addr      = cur_q.addr0 + idx_q;
	assign ctrl_byte = (cur_q.raw ? CTRL_RAW : CTRL_DECODED) | {5'd0, addr};
	assign gen_byte  = ph_q ? cur_q.data[idx_q[1:0]] : ctrl_byte;
	assign fin       = ph_q && ({1'b0, idx_q} == (cur_q.cnt - 4'd1));
	assign take      = !cur_v_q || (step && fin);
	assign pop       = take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q    <= 1'b0;
			cur_q      <= '0;
			idx_q      <= 3'd0;
			ph_q       <= 1'b0;
			out_v_q    <= 1'b0;
			out_byte_q <= 8'd0;
			out_mode_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (step) begin
				out_v_q    <= 1'b1;
				out_byte_q <= gen_byte;
				out_mode_q <= !ph_q;
				out_last_q <= fin;
				if (ph_q) begin
					ph_q  <= 1'b0;
					idx_q <= idx_q + 3'd1;
				end else begin
					ph_q <= 1'b1;
				end
			end else if (load_out) begin
				out_v_q <= 1'b0;
			end
			if (take) begin
				cur_v_q <= q_valid;
				if (q_valid) begin
					cur_q <= q_head;
					idx_q <= 3'd0;
					ph_q  <= 1'b0;
				end
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_mode_q;
	assign m_axis_tlast  = out_last_q;

endmodule

### hdl/seven_segment_write_sequencer.sv
// ----------------------------------------------------------------------------
// Seven-segment write sequencer
// Turns display commands into runs of latched bus writes for an 8-digit display.
// ----------------------------------------------------------------------------
// The slave stream takes one display command per word: the command code on
// tuser and the digit address, value, point and line selects on tdata. The
// master stream gives one bus write per word: the bus byte on tdata, a mode
// flag on tuser (high for the control byte of a digit, low for its data byte)
// and tlast on the final write of the command's run.
// A command of n digits produces 2n words (2 to 16); commands that produce
// none (decimal above 9999, hex8 to an address above seven) are dropped.
// A command passes the two front-end stages, the run queue, the current-run
// register and the output register before its first word appears. The output
// then carries one word per cycle while the receiver is ready, a rate set by
// the write back end. Commands are taken every cycle while the two-stage front
// end and the two-entry run queue have room, so the next command is already
// decoded when the current run ends and runs follow each other without gaps.
// When the receiver deasserts m_axis_tready, the output word holds, the back
// end waits, the queue fills and then s_axis_tready falls.
// Reset clears all valid flags and the queue; nothing else needs clearing.
// ----------------------------------------------------------------------------
module seven_segment_write_sequencer import ssws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [3:0] digit_addr, [19:4] value, [20] dp_on, [21] line_sel, [23:22] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [2:0] req_type
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] bus_byte
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] mode_high
	output logic                   m_axis_tuser,
	output logic                   m_axis_tlast
);

	logic      q_full;
	logic      push;
	ssws_run_t push_run;
	logic      pop;
	logic      q_valid;
	ssws_run_t q_head;

	// Front end: command decode and the decimal split.
	ssws_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_run      (push_run)
	);

	// Run queue decoupling decode from the write stream.
	ssws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_run   (push_run),
		.pop        (pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// Back end: one bus write per cycle from the current run while the receiver is ready.
	ssws_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// A run always ends on a data word.
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
		else $error("last word of a run is a control word");

	// A control word is followed at once by its data word.
	a_ctrl_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser |=> m_axis_tvalid && !m_axis_tuser)
		else $error("control word not followed by its data word");

	// Control words carry one of the two command prefixes.
	a_ctrl_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata[7:3] == CTRL_DECODED[7:3]) || (m_axis_tdata[7:3] == CTRL_RAW[7:3]))
		else $error("control word with a bad prefix");

endmodule

### test/tb_seven_segment_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the seven-segment write sequencer
// Sends display commands on the slave stream with random gaps and receiver
// stalls, and checks every bus word against an independent expansion of the
// command into control and data bytes.
// ----------------------------------------------------------------------------
module tb_seven_segment_write_sequencer;
	import ssws_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int DRAIN_MARGIN  = 12;   // covers commands that are dropped

	// Bus byte values for the display controller.
	localparam logic [7:0] LATCH_DECODED = 8'h58;
	localparam logic [7:0] LATCH_RAW     = 8'h78;
	localparam logic [7:0] POINT_OFF     = 8'h80;
	localparam logic [7:0] BLANK         = 8'h80;
	// "Err" glyphs, digit 0 in the lowest byte.
	localparam logic [3:0][7:0] ERR_GLYPH = {8'hF0, 8'h8C, 8'h8C, 8'hCF};

	typedef struct {
		ssws_req_t   kind;
		logic [3:0]  addr;
		logic [15:0] value;
		logic        dp_on;
		logic        line_sel;
	} display_cmd_t;

	typedef struct {
		logic [7:0] bus_byte;
		logic       mode_high;
		logic       last;
	} bus_write_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	bus_write_t pending_writes[$];
	int         error_count;
	int         words_checked;
	int         cycle_count;
	int         cmds_by_kind[8];
	int         cmds_sent;

	// Idling controls shared by the test tasks, the sender and the receiver.
	bit tx_idle_en;
	bit rx_idle_en;
	int rx_stall_left;
	int rx_hold_left;

	seven_segment_write_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding",
				cycle_count, pending_writes.size());
			$display("FAIL seven_segment_write_sequencer");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Expected bus words
	// ------------------------------------------------------------------------
	function automatic void queue_digit(input logic [7:0] ctrl, input logic [2:0] addr,
			input logic [7:0] data);
		bus_write_t w;
		w.bus_byte  = ctrl | {5'b0, addr};
		w.mode_high = 1'b1;
		w.last      = 1'b0;
		pending_writes.push_back(w);
		w.bus_byte  = data;
		w.mode_high = 1'b0;
		pending_writes.push_back(w);
	endfunction

	function automatic void expand_command(input display_cmd_t c);
		int         start;
		int         v;
		int         digits[4];
		logic [7:0] lo;
		logic [2:0] base;
		start = pending_writes.size();
		lo    = c.value[7:0];
		base  = c.line_sel ? 3'd4 : 3'd0;
		v     = int'(c.value);
		case (c.kind)
			REQ_DIGIT: begin
				queue_digit(LATCH_DECODED, c.addr[2:0],
					c.dp_on ? (lo & ~POINT_OFF) : (lo | POINT_OFF));
			end
			REQ_RAW: begin
				queue_digit(LATCH_RAW, c.addr[2:0], lo);
			end
			REQ_HEX16: begin
				for (int i = 0; i < 4; i++)
					queue_digit(LATCH_DECODED, base + 3'(i),
						POINT_OFF | {4'h0, c.value[15 - 4 * i -: 4]});
			end
			REQ_DEC16: begin
				// Values past 9999 cannot be shown and give no words at all.
				if (v <= 9999) begin
					digits[0] = v / 1000;
					digits[1] = (v % 1000) / 100;
					digits[2] = (v % 100) / 10;
					digits[3] = v % 10;
					for (int i = 0; i < 4; i++)
						queue_digit(LATCH_DECODED, base + 3'(i), POINT_OFF | 8'(digits[i]));
				end
			end
			REQ_HEX8: begin
				// The second digit wraps from seven back to zero.
				if (c.addr <= 4'd7) begin
					queue_digit(LATCH_DECODED, c.addr[2:0], POINT_OFF | {4'h0, lo[7:4]});
					queue_digit(LATCH_DECODED, c.addr[2:0] + 3'd1, POINT_OFF | {4'h0, lo[3:0]});
				end
			end
			REQ_CLR_ALL: begin
				for (int i = 0; i < 8; i++)
					queue_digit(LATCH_RAW, 3'(i), BLANK);
			end
			REQ_CLR_LN: begin
				for (int i = 0; i < 4; i++)
					queue_digit(LATCH_RAW, base + 3'(i), BLANK);
			end
			default: begin
				for (int i = 0; i < 4; i++)
					queue_digit(LATCH_RAW, base + 3'(i), ERR_GLYPH[i]);
			end
		endcase
		if (pending_writes.size() > start)
			pending_writes[pending_writes.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Command sender: called right after a rising edge, changes inputs at the
	// falling edge and returns at the edge that accepts the word.
	// ------------------------------------------------------------------------
	task automatic send_command(input display_cmd_t c);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {2'b00, c.line_sel, c.dp_on, c.value, c.addr};
		s_axis_tuser  = c.kind;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		expand_command(c);
		cmds_by_kind[int'(c.kind)]++;
		cmds_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// The sender holds back until every expected word is out, then allows
	// for a command still in flight that gives no words.
	task automatic wait_for_drain();
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_MARGIN) @(posedge clk);
	endtask

	function automatic display_cmd_t make_cmd(input ssws_req_t kind, input logic [3:0] addr,
			input logic [15:0] value, input logic dp_on, input logic line_sel);
		display_cmd_t c;
		c.kind     = kind;
		c.addr     = addr;
		c.value    = value;
		c.dp_on    = dp_on;
		c.line_sel = line_sel;
		return c;
	endfunction

	function automatic display_cmd_t random_command();
		display_cmd_t c;
		c.kind     = ssws_req_t'($urandom_range(0, 7));
		c.addr     = 4'($urandom_range(0, 15));
		c.value    = 16'($urandom_range(0, 16'hFFFF));
		c.dp_on    = 1'($urandom_range(0, 1));
		c.line_sel = 1'($urandom_range(0, 1));
		// Bias toward commands that actually produce words, keep some that don't.
		case (c.kind)
			REQ_DEC16: begin
				case ($urandom_range(0, 7))
					0:       c.value = 16'($urandom_range(9990, 10010));
					1:       ;
					default: c.value = 16'($urandom_range(0, 9999));
				endcase
			end
			REQ_HEX8: begin
				if ($urandom_range(0, 3) != 0)
					c.addr = 4'($urandom_range(0, 7));
			end
			default: ;
		endcase
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: tready is driven at the falling edge from a stall counter that
	// the checker reloads each time a word is taken and a hold counter set by the tests.
	// ------------------------------------------------------------------------
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_axis_tready = 1'b0;
				rx_hold_left--;
			end else if (rx_stall_left > 0) begin
				m_axis_tready = 1'b0;
				rx_stall_left--;
			end else begin
				m_axis_tready = arst_n;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Word checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_word
		bus_write_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_checked++;
			rx_stall_left = rx_idle_en ? $urandom_range(0, 14) : 0;
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected word byte=%02h mode=%b last=%b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast));
			end else begin
				want = pending_writes.pop_front();
				if (m_axis_tdata !== want.bus_byte)
					report_mismatch($sformatf("bus_byte %02h, expected %02h",
						m_axis_tdata, want.bus_byte));
				if (m_axis_tuser !== want.mode_high)
					report_mismatch($sformatf("mode_high %b, expected %b (byte %02h)",
						m_axis_tuser, want.mode_high, want.bus_byte));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("last %b, expected %b (byte %02h)",
						m_axis_tlast, want.last, want.bus_byte));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed_corners();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		// Single digits: address folding above seven, high byte ignored, point.
		send_command(make_cmd(REQ_DIGIT, 4'd0, 16'h0000, 1'b0, 1'b0));
		send_command(make_cmd(REQ_DIGIT, 4'd15, 16'hFFFF, 1'b1, 1'b1));
		send_command(make_cmd(REQ_DIGIT, 4'd9, 16'hAB7F, 1'b0, 1'b0));
		send_command(make_cmd(REQ_RAW, 4'd7, 16'h0000, 1'b1, 1'b0));
		send_command(make_cmd(REQ_RAW, 4'd8, 16'h12FF, 1'b0, 1'b1));
		send_command(make_cmd(REQ_RAW, 4'd12, 16'hFF5A, 1'b1, 1'b1));
		// Four-digit hex on both lines.
		send_command(make_cmd(REQ_HEX16, 4'd0, 16'h0000, 1'b0, 1'b0));
		send_command(make_cmd(REQ_HEX16, 4'd15, 16'hFFFF, 1'b1, 1'b1));
		send_command(make_cmd(REQ_HEX16, 4'd3, 16'hA5C3, 1'b0, 1'b1));
		// Decimal: zero, the top displayable value, just past it, all ones.
		send_command(make_cmd(REQ_DEC16, 4'd0, 16'd0, 1'b0, 1'b0));
		send_command(make_cmd(REQ_DEC16, 4'd0, 16'd9999, 1'b0, 1'b1));
		send_command(make_cmd(REQ_DEC16, 4'd0, 16'd10000, 1'b1, 1'b0));
		send_command(make_cmd(REQ_DEC16, 4'd0, 16'hFFFF, 1'b0, 1'b1));
		send_command(make_cmd(REQ_DEC16, 4'd5, 16'd1207, 1'b1, 1'b0));
		// Two-digit hex: plain, wrap at seven, addresses that give nothing.
		send_command(make_cmd(REQ_HEX8, 4'd0, 16'hFFAB, 1'b0, 1'b0));
		send_command(make_cmd(REQ_HEX8, 4'd7, 16'h00F0, 1'b1, 1'b1));
		send_command(make_cmd(REQ_HEX8, 4'd8, 16'h1234, 1'b0, 1'b0));
		send_command(make_cmd(REQ_HEX8, 4'd15, 16'hFFFF, 1'b1, 1'b1));
		// Clears and the error pattern.
		send_command(make_cmd(REQ_CLR_ALL, 4'd0, 16'h0000, 1'b0, 1'b0));
		send_command(make_cmd(REQ_CLR_LN, 4'd0, 16'h0000, 1'b0, 1'b0));
		send_command(make_cmd(REQ_CLR_LN, 4'd15, 16'hFFFF, 1'b1, 1'b1));
		send_command(make_cmd(REQ_ERROR, 4'd0, 16'h0000, 1'b0, 1'b0));
		send_command(make_cmd(REQ_ERROR, 4'd15, 16'hFFFF, 1'b1, 1'b1));
		// Dropped commands back to back with a productive one.
		send_command(make_cmd(REQ_DEC16, 4'd0, 16'd10001, 1'b0, 1'b0));
		send_command(make_cmd(REQ_DIGIT, 4'd3, 16'h0031, 1'b1, 1'b0));
		stop_sending();
		wait_for_drain();
	endtask

	// Random commands; the idling mix changes every forty commands so that
	// both sides see stretches of gaps and stretches without.
	task automatic test_random_commands(input int count);
		for (int i = 0; i < count; i++) begin
			tx_idle_en = ((i / 40) % 4) inside {0, 1};
			rx_idle_en = ((i / 40) % 4) inside {0, 2};
			send_command(random_command());
			if (i == count / 2) begin
				stop_sending();
				wait_for_drain();
			end
		end
		stop_sending();
		wait_for_drain();
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering, so the queue fills and the input is stalled.
	task automatic test_output_backpressure(input int count);
		tx_idle_en   = 1'b0;
		rx_idle_en   = 1'b1;
		rx_hold_left = 300;
		for (int i = 0; i < count; i++) begin
			if (i % 3 == 0)
				send_command(make_cmd(REQ_CLR_ALL, 4'($urandom_range(0, 15)),
					16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'($urandom_range(0, 1))));
			else
				send_command(random_command());
		end
		stop_sending();
		wait_for_drain();
	endtask

	// Full rate on both sides: runs must follow each other without slips.
	task automatic test_back_to_back(input int count);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int i = 0; i < count; i++)
			send_command(random_command());
		stop_sending();
		wait_for_drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		tx_idle_en    = 1'b1;
		rx_idle_en    = 1'b1;
		rx_stall_left = 0;
		rx_hold_left  = 0;
		error_count   = 0;
		words_checked = 0;
		cycle_count   = 0;
		cmds_sent     = 0;
		foreach (cmds_by_kind[k]) cmds_by_kind[k] = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_commands(330);
		test_output_backpressure(20);
		test_back_to_back(60);

		if (pending_writes.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived",
				pending_writes.size()));
		$display("Ran %0d commands (digit %0d, raw %0d, hex16 %0d, dec16 %0d, hex8 %0d,",
			cmds_sent, cmds_by_kind[0], cmds_by_kind[1], cmds_by_kind[2],
			cmds_by_kind[3], cmds_by_kind[4]);
		$display("  clear-all %0d, clear-line %0d, error %0d); %0d bus words checked, %0d errors",
			cmds_by_kind[5], cmds_by_kind[6], cmds_by_kind[7], words_checked, error_count);
		if (error_count == 0)
			$display("PASS seven_segment_write_sequencer");
		else
			$display("FAIL seven_segment_write_sequencer");
		$finish;
	end

endmodule

### seven_segment_write_sequencer.f
hdl/ssws_pkg.sv
hdl/ssws_front.sv
hdl/ssws_queue.sv
hdl/ssws_back.sv
hdl/seven_segment_write_sequencer.sv
test/tb_seven_segment_write_sequencer.sv
